// File: rtl/core/josephus_elimination_ring_assert.svh
// Assertion macros shared by the ring logic.
`ifndef JOSEPHUS_ELIMINATION_RING_ASSERT_SVH
`define JOSEPHUS_ELIMINATION_RING_ASSERT_SVH

// A property that must hold in every cycle outside reset.
`define JER_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that implies a result in the next cycle.
`define JER_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/jer_pkg.sv
// Types and constants shared by the elimination ring modules.
package jer_pkg;

   localparam int LABEL_W = 16;
   localparam int STEP_W  = 8;
   localparam int KIND_W  = 2;

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [KIND_W-1:0]  kind_type;

   localparam kind_type KIND_APPEND  = 2'd0;
   localparam kind_type KIND_PREPEND = 2'd1;
   localparam kind_type KIND_SOLVE   = 2'd2;

   localparam step_type STEP_K_RESET = 8'd3;

endpackage

// File: rtl/core/jer_ring_store.sv
// Label and link memories of the ring, one write port each and a shared read address.
module jer_ring_store #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     lbl_we,
   input  logic [$clog2(DEPTH)-1:0] lbl_waddr,
   input  jer_pkg::label_type       lbl_wdata,
   input  logic                     lnk_we,
   input  logic [$clog2(DEPTH)-1:0] lnk_waddr,
   input  logic [$clog2(DEPTH)-1:0] lnk_wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output jer_pkg::label_type       lbl_rdata,
   output logic [$clog2(DEPTH)-1:0] lnk_rdata
);
   import jer_pkg::*;

   localparam int SLOT_W = $clog2(DEPTH);

   label_type         label_mem [DEPTH];
   logic [SLOT_W-1:0] link_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         label_mem[lbl_waddr] <= lbl_wdata;
      end
      lbl_rdata <= label_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         link_mem[lnk_waddr] <= lnk_wdata;
      end
      lnk_rdata <= link_mem[raddr];
   end

endmodule

// File: rtl/core/josephus_elimination_ring.sv
// Top level of the elimination ring: load and solve control around the ring memories.
//
// Input transfers on req_* carry a kind and a label. An append or prepend
// stores the label at the tail or head of the ring and returns nothing, or
// returns one overflow result when the ring already holds MAX_PEOPLE labels.
// A solve walks the ring from the head and returns one result per removed
// label, the survivor last with rsp_last set, or a single rsp_empty_res
// result on an empty ring; the ring is empty afterwards. Kind 3 is ignored.
// csr_wr_en writes step_k from csr_wr_data; write it only idle. A load into
// an empty ring writes the link memory once and any other load writes a
// second link in ST_LINK2, since the link memory has one write port. A solve
// holds the input until its walk ends, and the walk follows the links one
// at a time through the single read port of the link memory, removing a
// label after step_k - 1 links (step_k of zero counts as one). An overflow
// or empty result is registered and valid in the cycle after its transfer.
// A full result register sits on rsp_*; when the receiver stalls, the walk
// holds at the next removal and no further transfer is taken on req_*.
// Reset is synchronous and leaves an empty ring with step_k equal to three.
`include "josephus_elimination_ring_assert.svh"

module josephus_elimination_ring #(
   parameter int MAX_PEOPLE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  jer_pkg::step_type  csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  jer_pkg::kind_type  req_kind,
   input  jer_pkg::label_type req_label,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jer_pkg::label_type rsp_label_res,
   output logic               rsp_last,
   output logic               rsp_empty_res,
   output logic               rsp_overflow
);
   import jer_pkg::*;

   localparam int SLOT_W = $clog2(MAX_PEOPLE);
   localparam int CNT_W  = $clog2(MAX_PEOPLE + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LINK2 = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   step_type          step_k_ff, step_k_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   step_type          skip_ff, skip_in;
   logic [SLOT_W-1:0] l2_addr_ff, l2_addr_in;
   logic [SLOT_W-1:0] l2_data_ff, l2_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   label_type         rsp_label_ff, rsp_label_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              rsp_free;
   logic              req_fire;
   logic              full;
   logic [SLOT_W-1:0] slot;
   step_type          skip_reload;

   logic              lbl_we;
   logic              lnk_we;
   logic [SLOT_W-1:0] lnk_waddr;
   logic [SLOT_W-1:0] lnk_wdata;
   logic [SLOT_W-1:0] raddr;
   label_type         lbl_rdata;
   logic [SLOT_W-1:0] lnk_rdata;

   jer_ring_store #(
      .DEPTH (MAX_PEOPLE)
   ) u_store (
      .clock     (clock),
      .lbl_we    (lbl_we),
      .lbl_waddr (slot),
      .lbl_wdata (req_label),
      .lnk_we    (lnk_we),
      .lnk_waddr (lnk_waddr),
      .lnk_wdata (lnk_wdata),
      .raddr     (raddr),
      .lbl_rdata (lbl_rdata),
      .lnk_rdata (lnk_rdata)
   );

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire    = req_valid && req_ready;
   assign full        = (count_ff == CNT_W'(MAX_PEOPLE));
   assign slot        = count_ff[SLOT_W-1:0];
   assign skip_reload = (step_k_ff == '0) ? '0 : step_k_ff - STEP_W'(1);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_label_res = rsp_label_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      step_k_in    = csr_wr_en ? csr_wr_data : step_k_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      left_in      = left_ff;
      skip_in      = skip_ff;
      l2_addr_in   = l2_addr_ff;
      l2_data_in   = l2_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_label_in = rsp_label_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      lbl_we       = 1'b0;
      lnk_we       = 1'b0;
      lnk_waddr    = slot;
      lnk_wdata    = slot;
      raddr        = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            raddr = head_ff;
            if (req_fire) begin
               case (req_kind)
                  KIND_APPEND, KIND_PREPEND: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_label_in = req_label;
                        rsp_last_in  = 1'b0;
                        rsp_empty_in = 1'b0;
                        rsp_ovf_in   = 1'b1;
                     end else begin
                        lbl_we   = 1'b1;
                        lnk_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           head_in = slot;
                           tail_in = slot;
                        end else if (req_kind == KIND_APPEND) begin
                           lnk_waddr  = tail_ff;
                           l2_addr_in = slot;
                           l2_data_in = head_ff;
                           tail_in    = slot;
                           state_in   = ST_LINK2;
                        end else begin
                           lnk_wdata  = head_ff;
                           l2_addr_in = tail_ff;
                           l2_data_in = slot;
                           head_in    = slot;
                           state_in   = ST_LINK2;
                        end
                     end
                  end
                  KIND_SOLVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_label_in = '0;
                        rsp_last_in  = 1'b0;
                        rsp_empty_in = 1'b1;
                        rsp_ovf_in   = 1'b0;
                     end else begin
                        cur_in   = head_ff;
                        prev_in  = tail_ff;
                        left_in  = count_ff;
                        skip_in  = skip_reload;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LINK2: begin
            lnk_we    = 1'b1;
            lnk_waddr = l2_addr_ff;
            lnk_wdata = l2_data_ff;
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            if (left_ff == CNT_W'(1)) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_label_in = lbl_rdata;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b0;
                  rsp_ovf_in   = 1'b0;
                  count_in     = '0;
                  head_in      = '0;
                  tail_in      = '0;
                  state_in     = ST_IDLE;
               end
            end else if (skip_ff != '0) begin
               prev_in = cur_ff;
               cur_in  = lnk_rdata;
               skip_in = skip_ff - STEP_W'(1);
               raddr   = lnk_rdata;
            end else if (rsp_free) begin
               // Unlink the current entry; the next entry's link is fetched in the same cycle.
               rsp_valid_in = 1'b1;
               rsp_label_in = lbl_rdata;
               rsp_last_in  = 1'b0;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = 1'b0;
               lnk_we       = 1'b1;
               lnk_waddr    = prev_ff;
               lnk_wdata    = lnk_rdata;
               cur_in       = lnk_rdata;
               raddr        = lnk_rdata;
               left_in      = left_ff - CNT_W'(1);
               skip_in      = skip_reload;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         step_k_ff    <= STEP_K_RESET;
         cur_ff       <= '0;
         prev_ff      <= '0;
         left_ff      <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         step_k_ff    <= step_k_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         left_ff      <= left_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l2_addr_ff   <= l2_addr_in;
      l2_data_ff   <= l2_data_in;
      rsp_label_ff <= rsp_label_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   `JER_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= CNT_W'(MAX_PEOPLE), "Ring count exceeds capacity.")
   `JER_ASSERT_ALWAYS(a_walk_left, clock, reset,
      (state_ff != ST_WALK) || (left_ff != '0 && left_ff <= count_ff),
      "Remaining count during a solve is out of range.")
   `JER_ASSERT_NEXT(a_survivor_clears, clock, reset,
      state_ff == ST_WALK && left_ff == CNT_W'(1) && rsp_free,
      count_ff == '0 && rsp_valid_ff && rsp_last_ff && state_ff == ST_IDLE,
      "Survivor transfer did not empty the ring.")
   `JER_ASSERT_ALWAYS(a_flags_exclusive, clock, reset,
      !rsp_valid_ff || $countones({rsp_last_ff, rsp_empty_ff, rsp_ovf_ff}) <= 1,
      "More than one result flag is set.")

endmodule

// File: test/tb_josephus_elimination_ring.sv
// Self-checking testbench for the Josephus elimination ring with a scoreboard class.

typedef struct packed {
   jer_pkg::label_type label;
   logic               is_last;
   logic               is_empty;
   logic               overflow;
} ring_result_type;

class ring_scoreboard;
   localparam int SLOTS = 64;

   jer_pkg::label_type labels[SLOTS];
   logic [5:0]         links[SLOTS];
   int unsigned        count;
   logic [5:0]         head_slot;
   logic [5:0]         tail_slot;
   jer_pkg::step_type  step;
   ring_result_type    awaited[$];
   int                 errors;

   function new();
      count = 0;
      head_slot = '0;
      tail_slot = '0;
      step = jer_pkg::STEP_K_RESET;
      errors = 0;
   endfunction

   function void set_step(jer_pkg::step_type value);
      step = value;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function void push_result(jer_pkg::label_type label, logic is_last, logic is_empty,
                             logic overflow);
      ring_result_type r;
      r.label = label;
      r.is_last = is_last;
      r.is_empty = is_empty;
      r.overflow = overflow;
      awaited.insert(awaited.size(), r);
   endfunction

   function void load_label(jer_pkg::label_type label, bit at_head);
      logic [5:0] slot;
      if (count >= SLOTS) begin
         push_result(label, 1'b0, 1'b0, 1'b1);
         return;
      end
      slot = 6'(count);
      labels[slot] = label;
      if (count == 0) begin
         head_slot = slot;
         tail_slot = slot;
         links[slot] = slot;
      end else if (at_head) begin
         links[slot] = head_slot;
         links[tail_slot] = slot;
         head_slot = slot;
      end else begin
         links[tail_slot] = slot;
         links[slot] = head_slot;
         tail_slot = slot;
      end
      count++;
   endfunction

   function void solve_ring();
      logic [5:0]  cur;
      logic [5:0]  prev;
      int unsigned left;
      int unsigned k;
      if (count == 0) begin
         push_result('0, 1'b0, 1'b1, 1'b0);
         return;
      end
      k = (step == 0) ? 1 : step;
      cur = head_slot;
      prev = tail_slot;
      left = count;
      while (left > 1) begin
         for (int unsigned i = 1; i < k; i++) begin
            prev = cur;
            cur = links[cur];
         end
         push_result(labels[cur], 1'b0, 1'b0, 1'b0);
         links[prev] = links[cur];
         cur = links[prev];
         left--;
      end
      push_result(labels[cur], 1'b1, 1'b0, 1'b0);
      count = 0;
      head_slot = '0;
      tail_slot = '0;
   endfunction

   function void note_input(jer_pkg::kind_type kind, jer_pkg::label_type label);
      case (kind)
         jer_pkg::KIND_APPEND:  load_label(label, 1'b0);
         jer_pkg::KIND_PREPEND: load_label(label, 1'b1);
         jer_pkg::KIND_SOLVE:   solve_ring();
         default: ;
      endcase
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_result(jer_pkg::label_type label, logic is_last, logic is_empty,
                     logic overflow);
      ring_result_type want;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("unexpected result label %h last %b empty %b overflow %b",
                                   label, is_last, is_empty, overflow));
         return;
      end
      want = awaited.pop_front();
      if (label !== want.label) begin
         report_mismatch($sformatf("label %h, expected %h", label, want.label));
      end
      if (is_last !== want.is_last) begin
         report_mismatch($sformatf("last %b, expected %b (label %h)", is_last, want.is_last,
                                   want.label));
      end
      if (is_empty !== want.is_empty) begin
         report_mismatch($sformatf("empty %b, expected %b", is_empty, want.is_empty));
      end
      if (overflow !== want.overflow) begin
         report_mismatch($sformatf("overflow %b, expected %b (label %h)", overflow,
                                   want.overflow, want.label));
      end
   endtask
endclass

module tb_josephus_elimination_ring;
   timeunit 1ns;
   timeprecision 1ps;

   import jer_pkg::*;

   localparam int       RING_SLOTS  = 64;
   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int       IDLE_PCT    = 23;
   localparam int       ITEM_TARGET = 450;
   localparam int       HOLD_CYCLES = 400;
   localparam int       LOAD_SETTLE = 8;
   localparam int       CYCLE_LIMIT = 2_000_000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      csr_wr_en = 1'b0;
   step_type  csr_wr_data = '0;
   logic      req_valid = 1'b0;
   logic      req_ready;
   kind_type  req_kind = KIND_APPEND;
   label_type req_label = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   label_type rsp_label_res;
   logic      rsp_last;
   logic      rsp_empty_res;
   logic      rsp_overflow;

   ring_scoreboard sb = new();
   int unsigned    items = 0;
   int unsigned    cycles = 0;
   bit             calm = 1'b0;
   bit             hold_req = 1'b0;
   step_type       step_now = STEP_K_RESET;

   josephus_elimination_ring #(.MAX_PEOPLE(RING_SLOTS)) u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_label     (req_label),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_label_res (rsp_label_res),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_label_res, rsp_last, rsp_empty_res, rsp_overflow);
         end
         if (req_valid && req_ready) begin
            sb.note_input(req_kind, req_label);
         end
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task send(kind_type kind, label_type label);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_label <= label;
      do @(posedge clock); while (!req_ready);
      if (kind != KIND_UNUSED) begin
         items++;
      end
   endtask

   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task write_step(step_type value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_step(value);
      step_now = value;
      csr_wr_en <= 1'b0;
   endtask

   task send_loads(int n);
      repeat (n) begin
         send($urandom_range(1) ? KIND_PREPEND : KIND_APPEND, label_type'($urandom()));
      end
   endtask

   function int ring_size();
      if (step_now > 16) begin
         return $urandom_range(1, 12);
      end
      return ($urandom_range(7) == 0) ? $urandom_range(1, RING_SLOTS) : $urandom_range(1, 10);
   endfunction

   initial begin
      int pick;
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(KIND_SOLVE, 16'h0000);
      send(KIND_APPEND, 16'h0000);
      send(KIND_SOLVE, 16'hFFFF);
      send(KIND_UNUSED, 16'hFFFF);
      for (int i = 1; i <= 5; i++) begin
         send(KIND_APPEND, label_type'(i));
      end
      send(KIND_PREPEND, 16'hFFFF);
      send(KIND_SOLVE, 16'h0000);
      settle();
      write_step(8'd1);
      send(KIND_APPEND, 16'hA5A5);
      send(KIND_APPEND, 16'h5A5A);
      send(KIND_PREPEND, 16'h8000);
      send(KIND_SOLVE, 16'h0000);
      settle();
      write_step(8'd0);
      send(KIND_APPEND, 16'h1234);
      send(KIND_APPEND, 16'h4321);
      send(KIND_SOLVE, 16'h0000);
      settle();
      write_step(8'd255);
      send(KIND_APPEND, 16'h0001);
      send(KIND_APPEND, 16'h0002);
      send(KIND_PREPEND, 16'hFFFE);
      send(KIND_SOLVE, 16'h0000);
      settle();
      write_step(8'd2);

      // Fill past capacity while the receiver holds off, so the block backs up.
      hold_req = 1'b1;
      send_loads(RING_SLOTS - int'(sb.count) + 2);
      send(KIND_SOLVE, label_type'($urandom()));
      send_loads(8);
      send(KIND_SOLVE, label_type'($urandom()));
      settle();

      phase = 0;
      while (items < ITEM_TARGET) begin
         settle();
         pick = $urandom_range(9);
         case (pick)
            0:       write_step(8'd1);
            1:       write_step(8'd255);
            2:       write_step(step_type'($urandom_range(255)));
            default: write_step(step_type'($urandom_range(2, 12)));
         endcase
         calm = (phase >= 3 && phase < 9);
         repeat ($urandom_range(1, 4)) begin
            if (items >= ITEM_TARGET) break;
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_loads(ring_size());
               send(KIND_SOLVE, label_type'($urandom()));
            end else if (pick < 78 && step_now <= 8) begin
               send_loads(RING_SLOTS - int'(sb.count) + $urandom_range(1, 4));
               send(KIND_SOLVE, label_type'($urandom()));
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 6)) begin
                  send(kind_type'($urandom_range(3)), label_type'($urandom()));
               end
            end else begin
               send_loads($urandom_range(1, 6));
            end
         end
         phase++;
      end
      calm = 1'b0;
      settle();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/jer_pkg.sv
rtl/core/jer_ring_store.sv
rtl/core/josephus_elimination_ring.sv
test/tb_josephus_elimination_ring.sv
